@@ hdl/bb3_pkg.sv @@
// Shared types, constants and the reciprocal table of the 3x3 box blur.
package bb3_pkg;

  localparam int MAX_WIDTH  = 1024;
  localparam int COL_W      = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
  localparam int EW_W       = $clog2(MAX_WIDTH + 1);
  localparam int IW_W       = 11;
  localparam int IH_W       = 16;
  localparam int ROW_W      = 17;
  localparam int OROW_W     = 16;
  localparam int PADDR_W    = 3;
  localparam int APB_W      = 32;

  localparam int FIFO_DEPTH = 4;
  localparam int FIFO_PTR_W = $clog2(FIFO_DEPTH);
  localparam int FIFO_CNT_W = $clog2(FIFO_DEPTH + 1);

  localparam int SUM_W      = 12;
  localparam int NUM_W      = 13;
  localparam int CNT_W      = 4;
  localparam int RCP_W      = 18;
  localparam int RCP_SHIFT  = 18;
  localparam int PROD_W     = NUM_W + RCP_W;

  localparam logic REG_IMAGE_WIDTH  = 1'b0;
  localparam logic REG_IMAGE_HEIGHT = 1'b1;

  typedef enum logic {
    CMD_PIXEL = 1'b0,
    CMD_FLUSH = 1'b1
  } bb3_cmd_t;

  typedef logic [23:0] bb3_pix_t;

  typedef struct packed {
    bb3_cmd_t    command;
    logic [7:0]  red_in;
    logic [7:0]  green_in;
    logic [7:0]  blue_in;
  } bb3_in_t;

  typedef struct packed {
    logic [7:0]  red_out;
    logic [7:0]  green_out;
    logic [7:0]  blue_out;
    logic        frame_end;
  } bb3_out_t;

  typedef struct packed {
    bb3_pix_t          pix;
    logic [COL_W-1:0]  col;
    logic              emit;
    logic              last;
    logic [8:0]        mask;
  } bb3_item_t;

  typedef struct packed {
    logic full;
    logic empty;
  } bb3_fifo_status_t;

  typedef struct packed {
    logic frame_start;
    logic inputs_done;
  } bb3_front_status_t;

  // ceil(2^18 / (2*cnt)); exact quotient for numerators below 4608
  function automatic logic [RCP_W-1:0] recip(input logic [CNT_W-1:0] cnt);
    logic [RCP_W-1:0] r;
    unique case (cnt)
      4'd2:    r = 18'd65536;
      4'd3:    r = 18'd43691;
      4'd4:    r = 18'd32768;
      4'd5:    r = 18'd26215;
      4'd6:    r = 18'd21846;
      4'd7:    r = 18'd18725;
      4'd8:    r = 18'd16384;
      4'd9:    r = 18'd14564;
      default: r = 18'd131072;
    endcase
    return r;
  endfunction

endpackage

@@ hdl/bb3_front.sv @@
// Front end: position tracking, item classification and edge masks.
module bb3_front (
  input  logic                       clk,
  input  logic                       rst,
  input  logic [bb3_pkg::IW_W-1:0]   image_width,
  input  logic [bb3_pkg::IH_W-1:0]   image_height,
  input  logic                       in_valid,
  output logic                       in_stall,
  input  bb3_pkg::bb3_in_t           in_data,
  input  bb3_pkg::bb3_fifo_status_t  q_status,
  output logic                       push,
  output bb3_pkg::bb3_item_t         item,
  output bb3_pkg::bb3_front_status_t status
);
  import bb3_pkg::*;

  logic [EW_W-1:0]   w;
  logic [IH_W-1:0]   h;
  logic [COL_W-1:0]  in_column, in_column_next;
  logic [COL_W-1:0]  out_column, out_column_next;
  logic [ROW_W-1:0]  in_row, in_row_next;
  logic [OROW_W-1:0] out_row, out_row_next;
  logic              accept, done, flush, emit, last, col_wrap, ocol_wrap;
  logic [2:0]        rok, cok;

  always_comb begin
    if (image_width == '0) begin
      w = EW_W'(1);
    end else if (32'(image_width) > MAX_WIDTH) begin
      w = EW_W'(MAX_WIDTH);
    end else begin
      w = EW_W'(image_width);
    end
    h = (image_height == '0) ? IH_W'(1) : image_height;

    in_stall  = q_status.full;
    accept    = in_valid && !q_status.full;
    flush     = (in_data.command == CMD_FLUSH);
    done      = 32'(in_row) >= 32'(h);
    emit      = (in_row >= ROW_W'(2)) || (in_row == ROW_W'(1) && in_column != '0);
    col_wrap  = (32'(in_column) + 32'd1) >= 32'(w);
    ocol_wrap = (32'(out_column) + 32'd1) >= 32'(w);
    last      = ((32'(out_row) + 32'd1) >= 32'(h)) && ocol_wrap;
    push      = accept && !(flush && !done);

    rok[0] = (out_row != '0);
    rok[1] = 32'(out_row) < 32'(h);
    rok[2] = (32'(out_row) + 32'd1) < 32'(h);
    cok[0] = (out_column != '0);
    cok[1] = 32'(out_column) < 32'(w);
    cok[2] = !ocol_wrap;

    item.pix  = done ? '0 : {in_data.red_in, in_data.green_in, in_data.blue_in};
    item.col  = in_column;
    item.emit = emit;
    item.last = emit && last;
    for (int r = 0; r < 3; r++) begin
      for (int c = 0; c < 3; c++) begin
        item.mask[r*3+c] = rok[r] && cok[c];
      end
    end

    in_column_next  = in_column;
    in_row_next     = in_row;
    out_column_next = out_column;
    out_row_next    = out_row;
    if (push) begin
      if (col_wrap) begin
        in_column_next = '0;
        in_row_next    = in_row + 1'b1;
      end else begin
        in_column_next = in_column + 1'b1;
      end
      if (emit) begin
        if (last) begin
          in_column_next  = '0;
          in_row_next     = '0;
          out_column_next = '0;
          out_row_next    = '0;
        end else if (ocol_wrap) begin
          out_column_next = '0;
          out_row_next    = out_row + 1'b1;
        end else begin
          out_column_next = out_column + 1'b1;
        end
      end
    end

    status.frame_start = (in_column == '0) && (in_row == '0) &&
                         (out_column == '0) && (out_row == '0);
    status.inputs_done = done;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      in_column  <= '0;
      in_row     <= '0;
      out_column <= '0;
      out_row    <= '0;
    end else begin
      in_column  <= in_column_next;
      in_row     <= in_row_next;
      out_column <= out_column_next;
      out_row    <= out_row_next;
    end
  end

endmodule

@@ hdl/bb3_fifo.sv @@
// Short request queue between the front end and the back end.
module bb3_fifo (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      push,
  input  bb3_pkg::bb3_item_t        push_item,
  input  logic                      pop,
  output bb3_pkg::bb3_item_t        head,
  output bb3_pkg::bb3_fifo_status_t status
);
  import bb3_pkg::*;

  bb3_item_t             entries [FIFO_DEPTH];
  logic [FIFO_PTR_W-1:0] wr_ptr, rd_ptr;
  logic [FIFO_CNT_W-1:0] count;

  always_comb begin
    head         = entries[rd_ptr];
    status.full  = (count == FIFO_CNT_W'(FIFO_DEPTH));
    status.empty = (count == '0);
  end

  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= push_item;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == FIFO_PTR_W'(FIFO_DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == FIFO_PTR_W'(FIFO_DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

@@ hdl/bb3_back.sv @@
// Back end: line stores, 3x3 window, masked sums and rounded division.
module bb3_back (
  input  logic                      clk,
  input  logic                      rst,
  input  bb3_pkg::bb3_fifo_status_t q_status,
  input  bb3_pkg::bb3_item_t        head,
  output logic                      pop,
  output logic                      out_valid,
  input  logic                      out_stall,
  output bb3_pkg::bb3_out_t         out_data
);
  import bb3_pkg::*;

  typedef enum logic [2:0] {
    S_IDLE,
    S_SHIFT,
    S_SUM,
    S_MUL,
    S_OUT
  } state_t;

  state_t             state;
  bb3_item_t          cur;
  bb3_pix_t           upper_mem [MAX_WIDTH];
  bb3_pix_t           lower_mem [MAX_WIDTH];
  bb3_pix_t           up_q, lo_q;
  bb3_pix_t           win [3][3];
  logic               wr_en;
  logic [SUM_W-1:0]   sum [3];
  logic [CNT_W-1:0]   cnt_raw, cnt_next, cnt;
  logic [NUM_W-1:0]   num_next [3];
  logic [NUM_W-1:0]   num [3];
  logic [PROD_W-1:0]  prod [3];

  always_comb begin
    pop     = (state == S_IDLE) && !q_status.empty;
    wr_en   = (state == S_SHIFT);
    cnt_raw = CNT_W'($countones(cur.mask));
    cnt_next = (cnt_raw == '0) ? CNT_W'(1) : cnt_raw;
    for (int ch = 0; ch < 3; ch++) begin
      sum[ch] = '0;
      for (int r = 0; r < 3; r++) begin
        for (int c = 0; c < 3; c++) begin
          if (cur.mask[r*3+c]) begin
            sum[ch] = sum[ch] + SUM_W'(win[r][c][(2-ch)*8 +: 8]);
          end
        end
      end
      num_next[ch] = NUM_W'({sum[ch], 1'b0}) + NUM_W'(cnt_next);
    end
  end

  // line stores: read at pop, read-modify-write in the shift cycle
  always_ff @(posedge clk) begin
    if (pop) begin
      up_q <= upper_mem[head.col];
      lo_q <= lower_mem[head.col];
    end
    if (wr_en) begin
      upper_mem[cur.col] <= lo_q;
      lower_mem[cur.col] <= cur.pix;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      out_valid <= 1'b0;
      for (int r = 0; r < 3; r++) begin
        for (int c = 0; c < 3; c++) begin
          win[r][c] <= '0;
        end
      end
    end else begin
      if (out_valid && !out_stall && state != S_OUT) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (pop) begin
            cur   <= head;
            state <= S_SHIFT;
          end
        end
        S_SHIFT: begin
          for (int r = 0; r < 3; r++) begin
            win[r][0] <= win[r][1];
            win[r][1] <= win[r][2];
          end
          win[0][2] <= up_q;
          win[1][2] <= lo_q;
          win[2][2] <= cur.pix;
          state     <= cur.emit ? S_SUM : S_IDLE;
        end
        S_SUM: begin
          num   <= num_next;
          cnt   <= cnt_next;
          state <= S_MUL;
        end
        S_MUL: begin
          for (int ch = 0; ch < 3; ch++) begin
            prod[ch] <= PROD_W'(num[ch]) * PROD_W'(recip(cnt));
          end
          state <= S_OUT;
        end
        S_OUT: begin
          if (!out_valid || !out_stall) begin
            out_valid          <= 1'b1;
            out_data.red_out   <= prod[0][RCP_SHIFT +: 8];
            out_data.green_out <= prod[1][RCP_SHIFT +: 8];
            out_data.blue_out  <= prod[2][RCP_SHIFT +: 8];
            out_data.frame_end <= cur.last;
            state              <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule

@@ hdl/box_blur_3x3_rgb.sv @@
// Top level of the streaming 3x3 RGB box blur with its register port.
//
//   channel  | direction | handshake                 | payload
//   ---------+-----------+---------------------------+-----------------------
//   pixel    | in        | pixel_valid / pixel_stall | command, red/green/blue
//   result   | out       | result_valid/result_stall | red/green/blue, frame_end
//   register | in        | psel/penable/pwrite/pready| image_width, image_height
//
// A pixel request that yields no result occupies the back end for the line store
// read and window shift; one that yields a result also for sum, multiply and result
// load. The back end pops no new request until it is through with the last one.
// A flush request before the last pixel of a frame is accepted and dropped.
// Reset is synchronous; line stores are not cleared, the window and counters are.
// A 4-entry queue stalls pixel requests when full; a stalled result holds.
module box_blur_3x3_rgb (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        pixel_valid,
  output logic                        pixel_stall,
  input  bb3_pkg::bb3_in_t            pixel,
  output logic                        result_valid,
  input  logic                        result_stall,
  output bb3_pkg::bb3_out_t           result,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [bb3_pkg::PADDR_W-1:0] paddr,
  input  logic [bb3_pkg::APB_W-1:0]   pwdata,
  output logic [bb3_pkg::APB_W-1:0]   prdata,
  output logic                        pready
);
  import bb3_pkg::*;

  logic [IW_W-1:0]   image_width;
  logic [IH_W-1:0]   image_height;
  logic              push, pop;
  bb3_item_t         push_item, head;
  bb3_fifo_status_t  fifo_status;
  bb3_front_status_t front_status;

  assign pready = 1'b1;

  always_comb begin
    if (paddr[2] == REG_IMAGE_HEIGHT) begin
      prdata = APB_W'(image_height);
    end else begin
      prdata = APB_W'(image_width);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      image_width  <= IW_W'(640);
      image_height <= IH_W'(480);
    end else if (psel && penable && pwrite && pready) begin
      if (paddr[2] == REG_IMAGE_WIDTH) begin
        image_width <= pwdata[IW_W-1:0];
      end else begin
        image_height <= pwdata[IH_W-1:0];
      end
    end
  end

  bb3_front u_front (
    .clk          (clk),
    .rst          (rst),
    .image_width  (image_width),
    .image_height (image_height),
    .in_valid     (pixel_valid),
    .in_stall     (pixel_stall),
    .in_data      (pixel),
    .q_status     (fifo_status),
    .push         (push),
    .item         (push_item),
    .status       (front_status)
  );

  bb3_fifo u_fifo (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_item (push_item),
    .pop       (pop),
    .head      (head),
    .status    (fifo_status)
  );

  bb3_back u_back (
    .clk       (clk),
    .rst       (rst),
    .q_status  (fifo_status),
    .head      (head),
    .pop       (pop),
    .out_valid (result_valid),
    .out_stall (result_stall),
    .out_data  (result)
  );

  // a frame-ending request puts every position counter back to the frame start
  a_last_restarts: assert property (@(posedge clk) disable iff (rst)
    (push && push_item.last) |=> front_status.frame_start)
    else $error("counters not cleared after frame end");

  a_pop_nonempty: assert property (@(posedge clk) disable iff (rst)
    pop |-> !fifo_status.empty)
    else $error("back end popped an empty queue");

  a_push_room: assert property (@(posedge clk) disable iff (rst)
    push |-> !fifo_status.full)
    else $error("front end pushed into a full queue");

  a_fifo_sane: assert property (@(posedge clk) disable iff (rst)
    !(fifo_status.full && fifo_status.empty))
    else $error("queue full and empty at once");

endmodule

@@ verif/box_blur_3x3_rgb_tb.sv @@
// Self-checking testbench for the streaming 3x3 RGB box blur and its register port.
module box_blur_3x3_rgb_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import bb3_pkg::*;

  localparam int RANDOM_ITEMS   = 850;
  localparam int HOLD_CYCLES    = 400;
  localparam int SETTLE_CYCLES  = 30;
  localparam int WATCHDOG_LIMIT = 3000;
  localparam int MAX_PRINTS     = 40;

  typedef enum logic {
    ROW_REQUEST,
    ROW_GEOMETRY
  } row_kind_t;

  typedef struct packed {
    row_kind_t         kind;
    bb3_in_t           req;
    logic              has_want;
    bb3_out_t          want;
    logic [IW_W-1:0]   geo_w;
    logic [IH_W-1:0]   geo_h;
  } dir_row_t;

  localparam bb3_in_t  FLUSH_REQ = '{CMD_FLUSH, 8'h00, 8'h00, 8'h00};
  localparam bb3_in_t  WHITE_REQ = '{CMD_PIXEL, 8'hff, 8'hff, 8'hff};
  localparam bb3_out_t NO_RES    = '0;
  localparam bb3_out_t WHITE_RES = '{8'hff, 8'hff, 8'hff, 1'b0};
  localparam bb3_out_t WHITE_END = '{8'hff, 8'hff, 8'hff, 1'b1};

  localparam int DIR_ROWS = 24;

  // 2x2 white frame, two 1x1 frames, then a 2x1 frame that rounds half up
  dir_row_t directed [DIR_ROWS] = '{
    '{ROW_REQUEST,  FLUSH_REQ, 1'b0, NO_RES,    11'd0, 16'd0},
    '{ROW_GEOMETRY, FLUSH_REQ, 1'b0, NO_RES,    11'd2, 16'd2},
    '{ROW_REQUEST,  WHITE_REQ, 1'b0, NO_RES,    11'd0, 16'd0},
    '{ROW_REQUEST,  WHITE_REQ, 1'b0, NO_RES,    11'd0, 16'd0},
    '{ROW_REQUEST,  FLUSH_REQ, 1'b0, NO_RES,    11'd0, 16'd0},
    '{ROW_REQUEST,  WHITE_REQ, 1'b0, NO_RES,    11'd0, 16'd0},
    '{ROW_REQUEST,  WHITE_REQ, 1'b1, WHITE_RES, 11'd0, 16'd0},
    '{ROW_REQUEST,  '{CMD_PIXEL, 8'h12, 8'h34, 8'h56}, 1'b1, WHITE_RES, 11'd0, 16'd0},
    '{ROW_REQUEST,  FLUSH_REQ, 1'b1, WHITE_RES, 11'd0, 16'd0},
    '{ROW_REQUEST,  FLUSH_REQ, 1'b1, WHITE_END, 11'd0, 16'd0},
    '{ROW_GEOMETRY, FLUSH_REQ, 1'b0, NO_RES,    11'd1, 16'd1},
    '{ROW_REQUEST,  '{CMD_PIXEL, 8'hff, 8'h00, 8'hff}, 1'b0, NO_RES, 11'd0, 16'd0},
    '{ROW_REQUEST,  FLUSH_REQ, 1'b0, NO_RES,    11'd0, 16'd0},
    '{ROW_REQUEST,  FLUSH_REQ, 1'b1, '{8'hff, 8'h00, 8'hff, 1'b1}, 11'd0, 16'd0},
    '{ROW_REQUEST,  FLUSH_REQ, 1'b0, NO_RES,    11'd0, 16'd0},
    '{ROW_REQUEST,  '{CMD_PIXEL, 8'h00, 8'hff, 8'h00}, 1'b0, NO_RES, 11'd0, 16'd0},
    '{ROW_REQUEST,  FLUSH_REQ, 1'b0, NO_RES,    11'd0, 16'd0},
    '{ROW_REQUEST,  FLUSH_REQ, 1'b1, '{8'h00, 8'hff, 8'h00, 1'b1}, 11'd0, 16'd0},
    '{ROW_GEOMETRY, FLUSH_REQ, 1'b0, NO_RES,    11'd2, 16'd1},
    '{ROW_REQUEST,  '{CMD_PIXEL, 8'h00, 8'hff, 8'hfe}, 1'b0, NO_RES, 11'd0, 16'd0},
    '{ROW_REQUEST,  '{CMD_PIXEL, 8'h01, 8'hfe, 8'hff}, 1'b0, NO_RES, 11'd0, 16'd0},
    '{ROW_REQUEST,  FLUSH_REQ, 1'b0, NO_RES,    11'd0, 16'd0},
    '{ROW_REQUEST,  FLUSH_REQ, 1'b1, '{8'h01, 8'hff, 8'hff, 1'b0}, 11'd0, 16'd0},
    '{ROW_REQUEST,  '{CMD_PIXEL, 8'haa, 8'h55, 8'haa}, 1'b1, '{8'h01, 8'hff, 8'hff, 1'b1},
      11'd0, 16'd0}
  };

  logic                clk = 1'b0;
  logic                rst = 1'b1;
  logic                pixel_valid = 1'b0;
  logic                pixel_stall;
  bb3_in_t             pixel = '0;
  logic                result_valid;
  logic                result_stall = 1'b0;
  bb3_out_t            result;
  logic                psel = 1'b0;
  logic                penable = 1'b0;
  logic                pwrite = 1'b0;
  logic [PADDR_W-1:0]  paddr = '0;
  logic [APB_W-1:0]    pwdata = '0;
  logic [APB_W-1:0]    prdata;
  logic                pready;

  // blur predictor state
  logic [IW_W-1:0]     geo_width = IW_W'(640);
  logic [IH_W-1:0]     geo_height = IH_W'(480);
  bb3_pix_t            row_above [MAX_WIDTH] = '{default: '0};
  bb3_pix_t            row_prev [MAX_WIDTH] = '{default: '0};
  bb3_pix_t            win_px [3][3] = '{default: '{default: '0}};
  logic [COL_W-1:0]    in_col = '0;
  logic [ROW_W-1:0]    in_row = '0;
  logic [COL_W-1:0]    out_col = '0;
  logic [OROW_W-1:0]   out_row = '0;

  bb3_out_t            pending_px [$];

  int unsigned         errors = 0;
  int unsigned         reqs_accepted = 0;
  int unsigned         results_seen = 0;
  int unsigned         frames_run = 0;
  int unsigned         settings_run = 0;
  int unsigned         live_items = 0;
  int unsigned         idle_cycles = 0;
  int unsigned         hold_left = 0;
  int unsigned         stall_left = 0;
  bit                  stall_now = 1'b0;
  bit                  hold_pending = 1'b0;
  bit                  quiet = 1'b0;

  box_blur_3x3_rgb u_dut (
    .clk          (clk),
    .rst          (rst),
    .pixel_valid  (pixel_valid),
    .pixel_stall  (pixel_stall),
    .pixel        (pixel),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .result       (result),
    .psel         (psel),
    .penable      (penable),
    .pwrite       (pwrite),
    .paddr        (paddr),
    .pwdata       (pwdata),
    .prdata       (prdata),
    .pready       (pready)
  );

  always #2 clk = ~clk;

  task automatic flag_mismatch(input string msg);
    errors++;
    if (errors <= MAX_PRINTS) $display("MISMATCH at %0t: %s", $time, msg);
  endtask

  function automatic bit blur_step(input bb3_in_t req, output bb3_out_t res);
    int unsigned w, h, cnt;
    int unsigned sum [3];
    bb3_pix_t    pix, up, lo, v;
    bit          done, emit, last;
    int          r, c;
    w = (geo_width == 0) ? 1 : (geo_width > MAX_WIDTH) ? MAX_WIDTH : geo_width;
    h = (geo_height == 0) ? 1 : geo_height;
    done = (in_row >= h);
    res = '0;
    if (req.command == CMD_FLUSH && !done) return 1'b0;
    pix = done ? '0 : {req.red_in, req.green_in, req.blue_in};
    up = row_above[in_col];
    lo = row_prev[in_col];
    row_above[in_col] = lo;
    row_prev[in_col] = pix;
    for (int i = 0; i < 3; i++) begin
      win_px[i][0] = win_px[i][1];
      win_px[i][1] = win_px[i][2];
    end
    win_px[0][2] = up;
    win_px[1][2] = lo;
    win_px[2][2] = pix;
    emit = (in_row >= 2) || (in_row == 1 && in_col >= 1);
    if (in_col + 1 >= w) begin
      in_col = '0;
      in_row++;
    end else begin
      in_col++;
    end
    if (!emit) return 1'b0;
    sum = '{0, 0, 0};
    cnt = 0;
    for (int dr = 0; dr < 3; dr++) begin
      r = int'(out_row) + dr - 1;
      if (r < 0 || r >= int'(h)) continue;
      for (int dc = 0; dc < 3; dc++) begin
        c = int'(out_col) + dc - 1;
        if (c < 0 || c >= int'(w)) continue;
        v = win_px[dr][dc];
        sum[0] += v[23:16];
        sum[1] += v[15:8];
        sum[2] += v[7:0];
        cnt++;
      end
    end
    if (cnt == 0) cnt = 1;
    res.red_out   = 8'((2 * sum[0] + cnt) / (2 * cnt));
    res.green_out = 8'((2 * sum[1] + cnt) / (2 * cnt));
    res.blue_out  = 8'((2 * sum[2] + cnt) / (2 * cnt));
    last = (out_row + 1 >= h) && (out_col + 1 >= w);
    res.frame_end = last;
    if (last) begin
      in_col = '0;
      in_row = '0;
      out_col = '0;
      out_row = '0;
    end else if (out_col + 1 >= w) begin
      out_col = '0;
      out_row++;
    end else begin
      out_col++;
    end
    return 1'b1;
  endfunction

  function automatic int unsigned sender_gap();
    int unsigned r;
    if (quiet) return 0;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  function automatic bb3_in_t random_pixel();
    bb3_in_t p;
    p.command = CMD_PIXEL;
    case ($urandom_range(0, 9))
      0:       {p.red_in, p.green_in, p.blue_in} = '0;
      1:       {p.red_in, p.green_in, p.blue_in} = '1;
      2:       {p.red_in, p.green_in, p.blue_in} = {{8{1'($urandom_range(0, 1))}},
                 {8{1'($urandom_range(0, 1))}}, {8{1'($urandom_range(0, 1))}}};
      default: {p.red_in, p.green_in, p.blue_in} = 24'($urandom());
    endcase
    return p;
  endfunction

  function automatic bb3_in_t flush_item();
    bb3_in_t p;
    p.command = CMD_FLUSH;
    {p.red_in, p.green_in, p.blue_in} = 24'($urandom());
    return p;
  endfunction

  task automatic push_request(input bb3_in_t req, input bit has_want, input bb3_out_t want);
    bb3_out_t    pred;
    int unsigned gap;
    pixel <= req;
    pixel_valid <= 1'b1;
    do @(posedge clk); while (pixel_stall !== 1'b0);
    reqs_accepted++;
    if (blur_step(req, pred)) pending_px.push_back(has_want ? want : pred);
    gap = sender_gap();
    if (gap != 0) begin
      pixel_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  task automatic wait_drain();
    pixel_valid <= 1'b0;
    while (pending_px.size() != 0) @(posedge clk);
  endtask

  task automatic reg_write(input logic idx, input logic [APB_W-1:0] value);
    logic [APB_W-1:0] got, keep;
    keep = (idx == REG_IMAGE_WIDTH) ? (value & 32'h7ff) : (value & 32'hffff);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= {idx, 2'b00};
    pwdata <= value;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (pready !== 1'b1);
    if (idx == REG_IMAGE_WIDTH) geo_width = keep[IW_W-1:0];
    else geo_height = keep[IH_W-1:0];
    penable <= 1'b0;
    pwrite <= 1'b0;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (pready !== 1'b1);
    got = prdata;
    psel <= 1'b0;
    penable <= 1'b0;
    if (got !== keep)
      flag_mismatch($sformatf("register %0d reads %0h, want %0h", idx, got, keep));
    @(posedge clk);
  endtask

  task automatic set_geometry(input int unsigned gw, input int unsigned gh);
    wait_drain();
    repeat (SETTLE_CYCLES) @(posedge clk);
    reg_write(REG_IMAGE_WIDTH, ($urandom() << IW_W) | gw);
    reg_write(REG_IMAGE_HEIGHT, ($urandom() << IH_W) | gh);
    settings_run++;
  endtask

  task automatic run_frame(input int unsigned w, input int unsigned h, input bit pause_mid);
    int unsigned n;
    n = w * h;
    for (int unsigned i = 0; i < n; i++) begin
      if ($urandom_range(0, 19) == 0) push_request(flush_item(), 1'b0, NO_RES);
      push_request(random_pixel(), 1'b0, NO_RES);
      if (pause_mid && i == n / 2) wait_drain();
    end
    // a pixel during the flush phase counts as a flush
    for (int unsigned j = 0; j <= w; j++)
      push_request(($urandom_range(0, 4) == 0) ? random_pixel() : flush_item(), 1'b0, NO_RES);
    if ($urandom_range(0, 3) == 0) push_request(flush_item(), 1'b0, NO_RES);
    live_items += n + w + 1;
    frames_run++;
  endtask

  always @(posedge clk) begin
    if (hold_pending) begin
      hold_pending = 1'b0;
      hold_left = HOLD_CYCLES;
    end
    if (hold_left != 0) begin
      hold_left--;
      result_stall <= 1'b1;
    end else if (quiet) begin
      result_stall <= 1'b0;
    end else begin
      if (stall_left == 0) begin
        stall_now = ($urandom_range(0, 3) == 0);
        if (!stall_now) stall_left = $urandom_range(1, 8);
        else if ($urandom_range(0, 9) == 0) stall_left = $urandom_range(10, 40);
        else stall_left = $urandom_range(1, 3);
      end
      stall_left--;
      result_stall <= stall_now;
    end
  end

  always @(posedge clk) begin
    bb3_out_t want;
    if (!rst && result_valid === 1'b1 && result_stall === 1'b0) begin
      results_seen++;
      if (pending_px.size() == 0) begin
        flag_mismatch($sformatf("result %0d arrived with nothing expected", results_seen));
      end else begin
        want = pending_px.pop_front();
        if (result.red_out !== want.red_out)
          flag_mismatch($sformatf("result %0d red %0h, want %0h",
                                  results_seen, result.red_out, want.red_out));
        if (result.green_out !== want.green_out)
          flag_mismatch($sformatf("result %0d green %0h, want %0h",
                                  results_seen, result.green_out, want.green_out));
        if (result.blue_out !== want.blue_out)
          flag_mismatch($sformatf("result %0d blue %0h, want %0h",
                                  results_seen, result.blue_out, want.blue_out));
        if (result.frame_end !== want.frame_end)
          flag_mismatch($sformatf("result %0d frame_end %0b, want %0b",
                                  results_seen, result.frame_end, want.frame_end));
      end
    end
  end

  always @(posedge clk) begin
    if ((pixel_valid && pixel_stall === 1'b0) || (result_valid === 1'b1 && !result_stall) || psel)
      idle_cycles = 0;
    else
      idle_cycles++;
    if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("No request or result moved for %0d cycles", WATCHDOG_LIMIT);
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  initial begin
    int unsigned gw, gh, ew, eh, nframes, phase;
    repeat (7) @(posedge clk);
    rst <= 1'b0;

    foreach (directed[i]) begin
      if (directed[i].kind == ROW_GEOMETRY)
        set_geometry(directed[i].geo_w, directed[i].geo_h);
      else
        push_request(directed[i].req, directed[i].has_want, directed[i].want);
    end

    phase = 0;
    while (live_items < RANDOM_ITEMS) begin
      case (phase)
        0: begin gw = 0; gh = 0; end
        1: begin gw = 1; gh = 6; end
        2: begin gw = 9; gh = 1; end
        3: begin gw = 8; gh = 6; end
        default: begin
          gw = ($urandom_range(0, 5) == 0) ? $urandom_range(13, 40) : $urandom_range(1, 12);
          gh = $urandom_range(1, 7);
        end
      endcase
      set_geometry(gw, gh);
      ew = (gw == 0) ? 1 : (gw > MAX_WIDTH) ? MAX_WIDTH : gw;
      eh = (gh == 0) ? 1 : gh;
      nframes = (ew * eh < 4) ? 4 : $urandom_range(1, 3);
      for (int unsigned f = 0; f < nframes && live_items < RANDOM_ITEMS; f++) begin
        quiet = (phase == 3) || ($urandom_range(0, 5) == 0);
        // output held off while requests keep coming, so the input backs up
        if (phase == 3 && f == 0) hold_pending = 1'b1;
        run_frame(ew, eh, (phase == 1 && f == 0) || ($urandom_range(0, 9) == 0));
      end
      phase++;
    end
    quiet = 1'b0;

    set_geometry(2047, 65535);

    wait_drain();
    repeat (SETTLE_CYCLES) @(posedge clk);

    $display("Blur run: %0d frames under %0d geometry settings, %0d requests, %0d results",
             frames_run, settings_run, reqs_accepted, results_seen);
    $display("Frames from 1x1 to 40x7 with zero geometry, register extremes, stray flushes, %0d-cycle output hold",
             HOLD_CYCLES);
    if (errors == 0)
      $display("Testbench completed without errors");
    else
      $display("Testbench completed WITH ERRORS");
    $finish;
  end

endmodule
